// ===== design/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types, codes and defaults of the contiguous block allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package cba_pkg;

   localparam int DefMaxBlocks = 16;
   localparam int DefAddrBits  = 16;
   localparam int DefIdBits    = 16;

   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_FREE    = 2'd1,
      MODE_COMPACT = 2'd2,
      MODE_READ    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_FIT   = 3'd1,
      ST_DUP_ID   = 3'd2,
      ST_NOT_FND  = 3'd3,
      ST_FULL     = 3'd4,
      ST_BAD_IDX  = 3'd5
   } status_type;

   localparam logic [0:0] CSR_MEMORY_SIZE = 1'b0;
   localparam logic [0:0] CSR_FIT_MODE    = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] block_id;
      logic [15:0] block_size;
      logic [3:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_id;
      logic [15:0] out_start;
      logic [15:0] out_end;
      logic [4:0]  entry_count;
      logic [15:0] free_space;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ID_SCAN,
      S_HOLE_SCAN,
      S_SHIFT_UP,
      S_INSERT,
      S_SHIFT_DOWN,
      S_COMPACT,
      S_READ,
      S_DONE
   } state_type;

endpackage : cba_pkg
`default_nettype wire

// ===== design/cba_ram.sv =====
// ----------------------------------------------------------------------------
// cba_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module cba_ram #(
   parameter int Width = 16,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule : cba_ram
`default_nettype wire

// ===== design/contiguous_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// contiguous_block_allocator_top
// Sorted block table in RAM, walked entry by entry by one sequencer with one
// shared compare/subtract path.
// ----------------------------------------------------------------------------
// Free, compact and allocate walk the table entry by entry; allocate may be
// rejected before the hole search, else also searches the holes. Each entry
// is read, then used, through the one RAM port; busy stays high until the
// strobe cycle, so the next beat is accepted at the edge that ends the strobe.
// Synchronous reset empties the table (count 0), free space = memory size.
// ----------------------------------------------------------------------------
`default_nettype none
module contiguous_block_allocator_top #(
   parameter int MaxBlocks = cba_pkg::DefMaxBlocks,
   parameter int AddrBits  = cba_pkg::DefAddrBits,
   parameter int IdBits    = cba_pkg::DefIdBits
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire cba_pkg::req_type req_data,
   output logic                  rsp_valid,
   output cba_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [0:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);
   import cba_pkg::*;

   localparam int IdxBits = $clog2(MaxBlocks);
   localparam int CntBits = $clog2(MaxBlocks + 1);
   localparam int RowBits = IdBits + 2 * AddrBits;

   state_type state_ff, state_in;
   logic [AddrBits-1:0] mem_size_ff, mem_size_in;
   logic                fit_ff, fit_in;
   logic [CntBits-1:0]  count_ff, count_in;
   logic [AddrBits-1:0] unalloc_ff, unalloc_in;
   req_type             req_ff, req_in;
   logic [CntBits-1:0]  ptr_ff, ptr_in;       // walk position
   logic                phase_ff, phase_in;   // 0 issue read, 1 use data
   logic                found_ff, found_in;
   logic [CntBits-1:0]  pick_ff, pick_in;
   logic [AddrBits-1:0] pick_len_ff, pick_len_in;
   logic [AddrBits-1:0] pick_hs_ff, pick_hs_in;
   logic [AddrBits-1:0] prev_end_ff, prev_end_in;
   logic [CntBits-1:0]  hit_ff, hit_in;
   logic [AddrBits-1:0] fs_ff, fs_in, fe_ff, fe_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                hit_flag_ff, rd_ok_ff;

   logic               ram_we;
   logic [IdxBits-1:0] ram_waddr, ram_raddr;
   logic [RowBits-1:0] ram_wdata, ram_rdata;
   logic [IdBits-1:0]  rd_id;
   logic [AddrBits-1:0] rd_s, rd_e;
   logic [AddrBits-1:0] req_size;
   logic [IdBits-1:0]   req_id;

   cba_ram #(.Width(RowBits), .Depth(MaxBlocks)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign {rd_id, rd_s, rd_e} = ram_rdata;
   assign req_size = AddrBits'(req_ff.block_size);
   assign req_id   = IdBits'(req_ff.block_id);

   // shared subtract: hole length or block length
   logic [AddrBits-1:0] sub_a, sub_b, sub_d;
   logic                sub_pos;
   assign sub_d   = sub_a - sub_b;
   assign sub_pos = sub_a > sub_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mem_size_ff  <= AddrBits'(65535);
         fit_ff       <= 1'b0;
         count_ff     <= '0;
         unalloc_ff   <= AddrBits'(65535);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mem_size_ff  <= mem_size_in;
         fit_ff       <= fit_in;
         count_ff     <= count_in;
         unalloc_ff   <= unalloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      ptr_ff      <= ptr_in;
      phase_ff    <= phase_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      pick_len_ff <= pick_len_in;
      pick_hs_ff  <= pick_hs_in;
      prev_end_ff <= prev_end_in;
      hit_ff      <= hit_in;
      fs_ff       <= fs_in;
      fe_ff       <= fe_in;
      rsp_ff      <= rsp_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (mode_type'(req_data.mode))
                  MODE_ALLOC:   state_in = S_ID_SCAN;
                  MODE_FREE:    state_in = S_ID_SCAN;
                  MODE_COMPACT: state_in = S_COMPACT;
                  MODE_READ:    state_in = S_READ;
                  default:      state_in = S_IDLE;
               endcase
            end
         end
         S_ID_SCAN: begin
            if (ptr_ff == count_ff) begin
               if (mode_type'(req_ff.mode) == MODE_FREE) begin
                  state_in = (hit_ff < count_ff) ? S_SHIFT_DOWN : S_DONE;
               end else if (req_size == '0 || req_size > unalloc_ff
                            || hit_ff < count_ff
                            || count_ff >= CntBits'(MaxBlocks)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_HOLE_SCAN;
               end
            end else if (phase_ff && rd_id == req_id) begin
               state_in = (mode_type'(req_ff.mode) == MODE_FREE) ? S_SHIFT_DOWN : S_DONE;
            end
         end
         S_HOLE_SCAN: begin
            if (phase_ff || ptr_ff == count_ff) begin
               if (ptr_ff == count_ff || (!fit_ff && found_in)) begin
                  state_in = found_in ? S_SHIFT_UP : S_DONE;
               end
            end
         end
         S_SHIFT_UP:   if (ptr_ff == pick_ff) state_in = S_INSERT;
         S_INSERT:     state_in = S_DONE;
         S_SHIFT_DOWN: if (ptr_ff + 1'b1 >= count_ff) state_in = S_DONE;
         S_COMPACT:    if (ptr_ff == count_ff) state_in = S_DONE;
         S_READ:       if (phase_ff) state_in = S_DONE;
         S_DONE:       state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mem_size_in  = mem_size_ff;
      fit_in       = fit_ff;
      count_in     = count_ff;
      unalloc_in   = unalloc_ff;
      req_in       = req_ff;
      ptr_in       = ptr_ff;
      phase_in     = phase_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      pick_len_in  = pick_len_ff;
      pick_hs_in   = pick_hs_ff;
      prev_end_in  = prev_end_ff;
      hit_in       = hit_ff;
      fs_in        = fs_ff;
      fe_in        = fe_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = ptr_ff[IdxBits-1:0];
      ram_wdata    = ram_rdata;
      ram_raddr    = ptr_ff[IdxBits-1:0];
      sub_a        = rd_s;
      sub_b        = prev_end_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in      = req_data;
               ptr_in      = '0;
               phase_in    = 1'b0;
               found_in    = 1'b0;
               hit_in      = count_ff;
               prev_end_in = '0;
               pick_in     = '0;
               pick_len_in = '0;
               pick_hs_in  = '0;
               fs_in       = '0;
               fe_in       = '0;
               rsp_in.status = ST_OK;
            end
            if (csr_we) begin
               unique case (csr_index)
                  CSR_MEMORY_SIZE: begin
                     mem_size_in = AddrBits'(csr_wdata);
                     count_in    = '0;
                     unalloc_in  = AddrBits'(csr_wdata);
                  end
                  CSR_FIT_MODE: fit_in = csr_wdata[0];
                  default: ;
               endcase
            end
         end
         S_ID_SCAN: begin
            // read entry, then compare; stop at first hit
            if (ptr_ff != count_ff) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
               end else begin
                  phase_in = 1'b0;
                  if (rd_id == req_id) begin
                     hit_in = ptr_ff;
                     fs_in  = rd_s;
                     fe_in  = rd_e;
                     ptr_in = ptr_ff;
                  end else begin
                     ptr_in = ptr_ff + 1'b1;
                  end
               end
            end
            if (state_in == S_HOLE_SCAN) begin
               ptr_in   = '0;
               phase_in = 1'b0;
            end
            if (state_in == S_SHIFT_DOWN) begin
               ptr_in   = (phase_ff && rd_id == req_id) ? ptr_ff : hit_ff;
               phase_in = 1'b0;
            end
         end
         S_HOLE_SCAN: begin
            if (ptr_ff != count_ff && !phase_ff) begin
               phase_in = 1'b1;
            end else begin
               sub_a = (ptr_ff == count_ff) ? mem_size_ff : rd_s;
               sub_b = prev_end_ff;
               phase_in = 1'b0;
               if (sub_pos && sub_d >= req_size
                   && (!found_ff || (fit_ff && sub_d < pick_len_ff))) begin
                  found_in    = 1'b1;
                  pick_in     = ptr_ff;
                  pick_len_in = sub_d;
                  pick_hs_in  = prev_end_ff;
               end
               prev_end_in = rd_e;
               ptr_in      = ptr_ff + 1'b1;
               if (state_in == S_SHIFT_UP) begin
                  ptr_in = count_ff;
               end
            end
         end
         S_SHIFT_UP: begin
            // move entry ptr-1 to ptr, top down; read first, write next cycle
            ram_raddr = IdxBits'(ptr_ff - 1'b1);
            if (ptr_ff != pick_ff) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
               end else begin
                  ram_we   = 1'b1;
                  phase_in = 1'b0;
                  ptr_in   = ptr_ff - 1'b1;
               end
            end
         end
         S_INSERT: begin
            ram_we     = 1'b1;
            ram_waddr  = pick_ff[IdxBits-1:0];
            ram_wdata  = {req_id, pick_hs_ff, pick_hs_ff + req_size};
            count_in   = count_ff + 1'b1;
            unalloc_in = unalloc_ff - req_size;
            fs_in      = pick_hs_ff;
            fe_in      = pick_hs_ff + req_size;
         end
         S_SHIFT_DOWN: begin
            ram_raddr = IdxBits'(ptr_ff + 1'b1);
            if (ptr_ff + 1'b1 < count_ff) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
               end else begin
                  ram_we   = 1'b1;
                  phase_in = 1'b0;
                  ptr_in   = ptr_ff + 1'b1;
               end
            end
            if (state_in == S_DONE) begin
               count_in   = count_ff - 1'b1;
               sub_a      = fe_ff;
               sub_b      = fs_ff;
               unalloc_in = unalloc_ff + sub_d;
            end
         end
         S_COMPACT: begin
            if (ptr_ff != count_ff) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
               end else begin
                  sub_a       = rd_e;
                  sub_b       = rd_s;
                  ram_we      = 1'b1;
                  ram_wdata   = {rd_id, prev_end_ff, prev_end_ff + sub_d};
                  prev_end_in = prev_end_ff + sub_d;
                  phase_in    = 1'b0;
                  ptr_in      = ptr_ff + 1'b1;
               end
            end
         end
         S_READ: begin
            ram_raddr = req_ff.entry_index[IdxBits-1:0];
            phase_in  = 1'b1;
         end
         S_DONE: begin
            rsp_valid_in      = 1'b1;
            rsp_in.out_id     = req_ff.block_id;
            rsp_in.out_start  = '0;
            rsp_in.out_end    = '0;
            unique case (mode_type'(req_ff.mode))
               MODE_ALLOC: begin
                  if (req_size == '0 || (req_size > unalloc_ff && !found_ff))
                     rsp_in.status = ST_NO_FIT;
                  else if (found_ff) begin
                     rsp_in.status    = ST_OK;
                     rsp_in.out_start = 16'(fs_ff);
                     rsp_in.out_end   = 16'(fe_ff);
                  end else if (hit_ff < count_ff) rsp_in.status = ST_DUP_ID;
                  else if (count_ff >= CntBits'(MaxBlocks)) rsp_in.status = ST_FULL;
                  else rsp_in.status = ST_NO_FIT;
               end
               MODE_FREE: begin
                  rsp_in.status    = hit_flag_ff ? ST_OK : ST_NOT_FND;
                  rsp_in.out_start = hit_flag_ff ? 16'(fs_ff) : '0;
                  rsp_in.out_end   = hit_flag_ff ? 16'(fe_ff) : '0;
               end
               MODE_COMPACT: begin
                  rsp_in.status = ST_OK;
                  rsp_in.out_id = '0;
               end
               default: begin
                  if (rd_ok_ff) begin
                     rsp_in.status    = ST_OK;
                     rsp_in.out_id    = 16'(rd_id);
                     rsp_in.out_start = 16'(rd_s);
                     rsp_in.out_end   = 16'(rd_e);
                  end else begin
                     rsp_in.status = ST_BAD_IDX;
                     rsp_in.out_id = '0;
                  end
               end
            endcase
            rsp_in.entry_count = 5'(count_ff);
            rsp_in.free_space  = 16'(unalloc_ff);
         end
         default: ;
      endcase
   end

   // free success flag and read-range flag
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) hit_flag_ff <= 1'b0;
      else if (state_ff == S_SHIFT_DOWN) hit_flag_ff <= 1'b1;
      rd_ok_ff <= (CntBits'(req_ff.entry_index) < count_ff)
                  && (32'(req_ff.entry_index) < MaxBlocks);
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(MaxBlocks)) else $error("count overflow");
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy) else $error("result while busy");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("double strobe");
endmodule : contiguous_block_allocator_top
`default_nettype wire
